@@ design/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// arc_pkg
// shared types and constants of the adaptive rice codec unit
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

    // default depth of the bit length history
    localparam int unsigned WINDOW_DEFAULT = 16;

    // widths fixed by the field definitions
    localparam int unsigned DATA_W = 32;
    localparam int unsigned K_W    = 6;
    localparam int unsigned CFG_W  = 6;
    localparam int unsigned IDX_W  = 2;

    // largest rice parameter, takes the whole word
    localparam logic [K_W-1:0] K_MAX   = 6'd32;
    localparam logic [K_W-1:0] K_RESET = 6'd8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DIRECTION     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INITIAL_K     = 2'd2;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // sample format codes, the reserved code acts as 32 bits
    localparam logic [1:0] FMT_8  = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    typedef struct packed {
        logic           direction;
        logic [1:0]     sample_format;
        logic [K_W-1:0] initial_k;
    } t_cfg;

    // one history update, issued when an item is worked
    typedef struct packed {
        logic           step;
        logic [K_W-1:0] bit_len;
    } t_win_req;

endpackage

`default_nettype wire

@@ design/adaptive_rice_codec_unit.sv @@
// ----------------------------------------------------------------------------
// adaptive_rice_codec_unit
// adaptive golomb-rice coder for audio samples, encode or decode per config
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       frame_start, sample_in,
//                                                    quotient_in, remainder_in
// output    out        o_out_valid / i_out_stall     quotient_out, remainder_out,
//                                                    remainder_bits, sample_out, next_k
// config    in         i_cfg_we, i_cfg_index         i_cfg_data
//
// one word per cycle sustained while the output does not stall; a word passes
// through the input register and then appears at the output register
// the rate is set by the rice parameter loop: map, bit length, history sum and
// the reciprocal multiply are all combinational and settle before the next word
// synchronous active-low reset; no clearing pass, history entries are only used
// once every slot has been written after reset or the last frame start
// a stalled output holds its word; the input register still fills, then stalls
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_rice_codec_unit #(
    parameter int unsigned WINDOW = arc_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [arc_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [arc_pkg::CFG_W-1:0]           i_cfg_data,
    // input words
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_frame_start,
    input  wire logic signed [arc_pkg::DATA_W-1:0]   i_sample_in,
    input  wire logic [arc_pkg::DATA_W-1:0]          i_quotient_in,
    input  wire logic [arc_pkg::DATA_W-1:0]          i_remainder_in,
    // result words
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [arc_pkg::DATA_W-1:0]               o_quotient_out,
    output logic [arc_pkg::DATA_W-1:0]               o_remainder_out,
    output logic [arc_pkg::K_W-1:0]                  o_remainder_bits,
    output logic signed [arc_pkg::DATA_W-1:0]        o_sample_out,
    output logic [arc_pkg::K_W-1:0]                  o_next_k
);

    // configuration registers
    arc_pkg::t_cfg r_cfg;

    // input register
    logic                              r_in_valid;
    logic                              r_frame_start;
    logic signed [arc_pkg::DATA_W-1:0] r_sample_in;
    logic [arc_pkg::DATA_W-1:0]        r_quotient_in;
    logic [arc_pkg::DATA_W-1:0]        r_remainder_in;

    // result register
    logic                              r_out_valid;
    logic [arc_pkg::DATA_W-1:0]        r_quotient_out;
    logic [arc_pkg::DATA_W-1:0]        r_remainder_out;
    logic [arc_pkg::K_W-1:0]           r_remainder_bits;
    logic signed [arc_pkg::DATA_W-1:0] r_sample_out;
    logic [arc_pkg::K_W-1:0]           r_next_k;

    // datapath
    logic                              adv;
    logic                              in_acc;
    logic [arc_pkg::K_W-1:0]           k_use;
    logic [arc_pkg::K_W-1:0]           next_k;
    logic [arc_pkg::DATA_W-1:0]        q_out;
    logic [arc_pkg::DATA_W-1:0]        rem_out;
    logic signed [arc_pkg::DATA_W-1:0] s_out;
    logic [arc_pkg::K_W-1:0]           bit_len;
    arc_pkg::t_win_req                 win_req;

    // input word moves to the result register when that is empty or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= arc_pkg::DIR_ENCODE;
            r_cfg.sample_format <= arc_pkg::FMT_32;
            r_cfg.initial_k     <= arc_pkg::K_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arc_pkg::CFG_DIRECTION:     r_cfg.direction     <= i_cfg_data[0];
                arc_pkg::CFG_SAMPLE_FORMAT: r_cfg.sample_format <= i_cfg_data[1:0];
                arc_pkg::CFG_INITIAL_K:     r_cfg.initial_k     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_frame_start  <= i_frame_start;
            r_sample_in    <= i_sample_in;
            r_quotient_in  <= i_quotient_in;
            r_remainder_in <= i_remainder_in;
        end
    end

    // history and k adaptation; k_use already reflects a frame start
    assign win_req.step    = adv;
    assign win_req.bit_len = bit_len;

    arc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_start (r_frame_start && r_in_valid),
        .i_initial_k   (r_cfg.initial_k),
        .i_req         (win_req),
        .o_k_use       (k_use),
        .o_next_k      (next_k)
    );

    // mapping and quotient/remainder split for the word in the input register
    arc_map u_map (
        .i_cfg           (r_cfg),
        .i_k             (k_use),
        .i_sample_in     (r_sample_in),
        .i_quotient_in   (r_quotient_in),
        .i_remainder_in  (r_remainder_in),
        .o_quotient_out  (q_out),
        .o_remainder_out (rem_out),
        .o_sample_out    (s_out),
        .o_bit_len       (bit_len)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quotient_out   <= q_out;
            r_remainder_out  <= rem_out;
            r_remainder_bits <= k_use;
            r_sample_out     <= s_out;
            r_next_k         <= next_k;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_quotient_out   = r_quotient_out;
    assign o_remainder_out  = r_remainder_out;
    assign o_remainder_bits = r_remainder_bits;
    assign o_sample_out     = r_sample_out;
    assign o_next_k         = r_next_k;

    // a worked word always lands in the result register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("worked word not presented at output");

    // stall toward the source only while a word is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing held");

    // remainder never carries bits above the parameter used
    a_rem_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_remainder_bits == arc_pkg::K_MAX) ||
                         ((r_remainder_out >> r_remainder_bits) == 32'd0)))
        else $error("remainder wider than rice parameter");

endmodule

`default_nettype wire

@@ design/arc_map.sv @@
// ----------------------------------------------------------------------------
// arc_map
// sample mapping, quotient and remainder split, and the inverse for decode
// ----------------------------------------------------------------------------
`default_nettype none

module arc_map (
    input  wire arc_pkg::t_cfg                   i_cfg,
    input  wire logic [arc_pkg::K_W-1:0]         i_k,
    input  wire logic signed [arc_pkg::DATA_W-1:0] i_sample_in,
    input  wire logic [arc_pkg::DATA_W-1:0]      i_quotient_in,
    input  wire logic [arc_pkg::DATA_W-1:0]      i_remainder_in,
    output logic [arc_pkg::DATA_W-1:0]           o_quotient_out,
    output logic [arc_pkg::DATA_W-1:0]           o_remainder_out,
    output logic signed [arc_pkg::DATA_W-1:0]    o_sample_out,
    output logic [arc_pkg::K_W-1:0]              o_bit_len
);

    // sign extend from the configured sample width
    function automatic logic [31:0] sign_fit(input logic [1:0] fmt, input logic [31:0] v);
        logic [31:0] res;
        case (fmt)
            arc_pkg::FMT_8:  res = {{24{v[7]}}, v[7:0]};
            arc_pkg::FMT_16: res = {{16{v[15]}}, v[15:0]};
            default:         res = v;
        endcase
        return res;
    endfunction

    // position of the top set bit plus one, zero for zero
    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [31:0] w;
        logic [4:0]  p;
        w = v;
        p = '0;
        if (|w[31:16]) begin
            p[4] = 1'b1;
            w    = {16'b0, w[31:16]};
        end
        if (|w[15:8]) begin
            p[3] = 1'b1;
            w    = {24'b0, w[15:8]};
        end
        if (|w[7:4]) begin
            p[2] = 1'b1;
            w    = {28'b0, w[7:4]};
        end
        if (|w[3:2]) begin
            p[1] = 1'b1;
            w    = {30'b0, w[3:2]};
        end
        if (w[1]) begin
            p[0] = 1'b1;
        end
        return (v == 32'd0) ? 6'd0 : ({1'b0, p} + 6'd1);
    endfunction

    logic        full_k;
    logic [31:0] mask;
    logic [31:0] x;
    logic [31:0] enc_mapped;
    logic [31:0] dec_hi;
    logic [31:0] dec_mapped;
    logic [31:0] unmapped;
    logic [31:0] mapped;

    assign full_k = (i_k == arc_pkg::K_MAX);
    assign mask   = full_k ? '1 : ((32'd1 << i_k[4:0]) - 32'd1);

    // zigzag: 2x for x >= 0, 2|x|-1 otherwise
    assign x          = sign_fit(i_cfg.sample_format, i_sample_in);
    assign enc_mapped = {x[30:0], 1'b0} ^ {32{x[31]}};

    // quotient field sits above the remainder, so the add is an or
    assign dec_hi     = full_k ? 32'd0 : (i_quotient_in << i_k[4:0]);
    assign dec_mapped = dec_hi | (i_remainder_in & mask);
    assign unmapped   = {1'b0, dec_mapped[31:1]} ^ {32{dec_mapped[0]}};

    always_comb begin
        if (i_cfg.direction == arc_pkg::DIR_DECODE) begin
            mapped          = dec_mapped;
            o_quotient_out  = '0;
            o_remainder_out = '0;
            o_sample_out    = sign_fit(i_cfg.sample_format, unmapped);
        end else begin
            mapped          = enc_mapped;
            o_quotient_out  = full_k ? 32'd0 : (enc_mapped >> i_k[4:0]);
            o_remainder_out = enc_mapped & mask;
            o_sample_out    = '0;
        end
    end

    assign o_bit_len = bit_len(mapped);

endmodule

`default_nettype wire

@@ design/arc_window.sv @@
// ----------------------------------------------------------------------------
// arc_window
// bit length history ring, running sum and rice parameter adaptation
// ----------------------------------------------------------------------------
`default_nettype none

module arc_window #(
    parameter int unsigned WINDOW = arc_pkg::WINDOW_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_frame_start,
    input  wire logic [arc_pkg::K_W-1:0] i_initial_k,
    input  wire arc_pkg::t_win_req       i_req,
    output logic [arc_pkg::K_W-1:0]      o_k_use,
    output logic [arc_pkg::K_W-1:0]      o_next_k
);

    localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = $clog2(32 * WINDOW + 1);
    // sum / WINDOW as a multiply by a rounded up reciprocal, exact for every sum
    localparam int unsigned DIV_L  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int unsigned DIV_SH = SUM_W + DIV_L;
    localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + WINDOW - 1) / WINDOW;
    localparam int unsigned M_W    = SUM_W + 2;
    localparam int unsigned PROD_W = SUM_W + M_W;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
    localparam logic [M_W-1:0]    RECIP    = M_W'(DIV_M);

    logic [arc_pkg::K_W-1:0] mem [WINDOW];

    logic [arc_pkg::K_W-1:0] r_k;
    logic [arc_pkg::K_W-1:0] n_k;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        n_sum;
    logic [PTR_W-1:0]        r_ptr;
    logic [PTR_W-1:0]        n_ptr;
    logic [arc_pkg::K_W-1:0] r_old;

    logic [arc_pkg::K_W-1:0] init_sat;
    logic [arc_pkg::K_W-1:0] k_e;
    logic [FILL_W-1:0]       fill_e;
    logic [SUM_W-1:0]        sum_e;
    logic [PTR_W-1:0]        ptr_e;
    logic [SUM_W-1:0]        upd_sum;
    logic [PROD_W-1:0]       prod;
    logic [arc_pkg::K_W-1:0] div_k;
    logic                    full;

    assign init_sat = (i_initial_k > arc_pkg::K_MAX) ? arc_pkg::K_MAX : i_initial_k;

    // frame start clears the history ahead of this item
    assign k_e    = i_frame_start ? init_sat : r_k;
    assign fill_e = i_frame_start ? '0 : r_fill;
    assign sum_e  = i_frame_start ? '0 : r_sum;
    assign ptr_e  = i_frame_start ? '0 : r_ptr;
    assign full   = (fill_e == FILL_MAX);

    assign upd_sum = full ? (sum_e - SUM_W'(r_old) + SUM_W'(i_req.bit_len))
                          : (sum_e + SUM_W'(i_req.bit_len));
    assign prod    = PROD_W'(upd_sum) * PROD_W'(RECIP);
    assign div_k   = prod[DIV_SH +: arc_pkg::K_W];

    always_comb begin
        n_k    = r_k;
        n_fill = r_fill;
        n_sum  = r_sum;
        n_ptr  = r_ptr;
        if (i_req.step) begin
            n_sum  = upd_sum;
            n_ptr  = (ptr_e == PTR_LAST) ? '0 : (ptr_e + PTR_W'(1));
            if (full) begin
                n_fill = fill_e;
                n_k    = div_k;
            end else begin
                n_fill = fill_e + FILL_W'(1);
                n_k    = k_e;
            end
        end
    end

    assign o_k_use  = k_e;
    assign o_next_k = n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= arc_pkg::K_RESET;
            r_fill <= '0;
            r_sum  <= '0;
            r_ptr  <= '0;
        end else begin
            r_k    <= n_k;
            r_fill <= n_fill;
            r_sum  <= n_sum;
            r_ptr  <= n_ptr;
        end
    end

    // ring write at the slot in use
    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            mem[ptr_e] <= i_req.bit_len;
        end
    end

    // fetch the oldest entry for the slot the next item uses, with write bypass
    always_ff @(posedge i_clk) begin
        if (i_req.step && (ptr_e == n_ptr)) begin
            r_old <= i_req.bit_len;
        end else begin
            r_old <= mem[n_ptr];
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("history fill beyond window depth");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= arc_pkg::K_MAX)
        else $error("rice parameter beyond 32");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W + 6)'(r_sum) <= ((SUM_W + 6)'(r_fill) << 5))
        else $error("history sum exceeds 32 per stored entry");

endmodule

`default_nettype wire
